>>> sv/mvm_pkg.sv
package mvm_pkg;

	// fixed field widths
	localparam int unsigned POS_W = 9;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned ROW_W = 16;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned ACC_W = 48;
	localparam int unsigned CFG_DATA_W = 16;

	// queue depths
	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// register indexes
	localparam logic [0:0] REG_COLUMN_COUNT = 1'b0;
	localparam logic [0:0] REG_ROW_COUNT = 1'b1;

	// request function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MATRIX = 1'b1;

	localparam logic [POS_W-1:0] COLUMN_COUNT_RESET = 9'd256;
	localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 16'd1;

	typedef struct packed {
		logic func;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] row_result;
		logic [ROW_W-1:0] row_index;
		logic last_row;
	} result_t;

	typedef struct packed {
		logic [0:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_req_t;

	// classified request handed from front to back
	typedef struct packed {
		logic is_mat;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] value;
		logic row_end;
		logic [ROW_W-1:0] row_idx;
		logic last;
	} op_t;

endpackage

>>> sv/matrix_vector_multiply_top.sv
// dense matrix-vector multiply y = A*x on a Q8.8 stream: func 0 requests load the vector
// store in order (wrapping after column_count elements), func 1 requests stream the matrix
// row by row, and each row's last column yields one Q32.16 dot product with its row index
// and a final-row flag. the block takes one request per clock, loads and matrix elements
// alike; a row-end matrix request passes the command queue, vector store read and multiply,
// then the accumulated sum enters the result queue. the sustained rate drops below one per
// clock only when the four-entry result queue, counted together with the results still
// in the pipeline, is full because the consumer is not popping. configuration writes are
// always taken (cfg_ready is tied high) and must be made only while the block is idle.
module matrix_vector_multiply_top import mvm_pkg::*; #(
	parameter int unsigned MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	// request side
	input logic push,
	input in_item_t item,
	output logic full,
	// result side
	output result_t result,
	output logic empty,
	input logic pop,
	// configuration writes
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_req_t cfg
);

	// front to command queue
	logic cmd_push;
	op_t cmd_in;
	// command queue to back
	op_t cmd_out;
	logic cmd_empty;
	logic cmd_pop;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

	assign cfg_ready = 1'b1;

	// front: register file, load/column/row positions, request classification
	mvm_front #(
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.q_full(full),
		.q_push(cmd_push),
		.op(cmd_in),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg(cfg)
	);

	// short queue that lets front and back stall on their own
	mvm_queue #(
		.item_t(op_t),
		.DEPTH(CMD_DEPTH)
	) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wr_item(cmd_in),
		.pop(cmd_pop),
		.rd_item(cmd_out),
		.full(full),
		.empty(cmd_empty),
		.count(cmd_count)
	);

	// back: vector store, multiplier, accumulator, result queue
	mvm_back #(
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op(cmd_out),
		.q_empty(cmd_empty),
		.q_pop(cmd_pop),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	// queue occupancy must agree with its flags
	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_count == '0) == cmd_empty)
		else $error("command queue count and empty disagree");

	a_cmd_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd_empty)
		else $error("command queue full and empty at once");

	a_cmd_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && !full |=> !cmd_empty)
		else $error("accepted request lost from command queue");

endmodule

>>> sv/mvm_queue.sv
module mvm_queue #(
	parameter type item_t = logic,
	parameter int unsigned DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t wr_item,
	input logic pop,
	output item_t rd_item,
	output logic full,
	output logic empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign rd_item = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> sv/mvm_front.sv
module mvm_front import mvm_pkg::*; #(
	parameter int unsigned MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input in_item_t item,
	input logic q_full,
	output logic q_push,
	output op_t op,
	input logic cfg_valid,
	input cfg_req_t cfg
);

	// the count field cannot exceed its own width, so larger stores need no clamp
	localparam logic [POS_W:0] MAXC = (MAX_COLS > (2**POS_W - 1))
		? (POS_W+1)'(2**POS_W - 1)
		: (POS_W+1)'(MAX_COLS);

	logic [POS_W-1:0] col_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [POS_W-1:0] load_pos_q;
	logic [POS_W-1:0] col_pos_q;
	logic [ROW_W-1:0] row_pos_q;

	logic [POS_W:0] cols;
	logic [ROW_W:0] rows;
	logic [POS_W-1:0] ld_pos;
	logic [POS_W:0] ld_inc;
	logic [POS_W-1:0] ld_next;
	logic [POS_W-1:0] col_sel;
	logic [POS_W:0] col_inc;
	logic [POS_W:0] cols_m1;
	logic row_end;
	logic [ROW_W:0] row_inc;
	logic last;
	logic accept;

	always_comb begin
		// clamp the count to 1..MAX_COLS
		cols = {1'b0, col_count_q};
		if (cols == '0) begin
			cols = (POS_W+1)'(1);
		end
		if (cols > MAXC) begin
			cols = MAXC;
		end
		rows = (row_count_q == '0) ? (ROW_W+1)'(1) : {1'b0, row_count_q};

		ld_pos = ({1'b0, load_pos_q} >= cols) ? '0 : load_pos_q;
		ld_inc = {1'b0, ld_pos} + 1'b1;
		ld_next = (ld_inc >= cols) ? '0 : ld_inc[POS_W-1:0];

		cols_m1 = cols - 1'b1;
		col_sel = ({1'b0, col_pos_q} < cols) ? col_pos_q : cols_m1[POS_W-1:0];
		col_inc = {1'b0, col_pos_q} + 1'b1;
		row_end = (col_inc >= cols);

		row_inc = {1'b0, row_pos_q} + 1'b1;
		last = (row_inc >= rows);
	end

	assign accept = push && !q_full;
	assign q_push = accept;

	always_comb begin
		op.is_mat = (item.func == FUNC_MATRIX);
		op.pos = op.is_mat ? col_sel : ld_pos;
		op.value = item.value;
		op.row_end = row_end;
		op.row_idx = row_pos_q;
		op.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= COLUMN_COUNT_RESET;
			row_count_q <= ROW_COUNT_RESET;
			load_pos_q <= '0;
			col_pos_q <= '0;
			row_pos_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg.index)
					REG_COLUMN_COUNT: col_count_q <= cfg.data[POS_W-1:0];
					REG_ROW_COUNT: row_count_q <= cfg.data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (item.func == FUNC_MATRIX) begin
					if (row_end) begin
						col_pos_q <= '0;
						row_pos_q <= last ? '0 : row_inc[ROW_W-1:0];
					end else begin
						col_pos_q <= col_inc[POS_W-1:0];
					end
				end else begin
					load_pos_q <= ld_next;
				end
			end
		end
	end

endmodule

>>> sv/mvm_back.sv
module mvm_back import mvm_pkg::*; #(
	parameter int unsigned MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	input op_t op,
	input logic q_empty,
	output logic q_pop,
	output result_t result,
	output logic empty,
	input logic pop
);

	localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic signed [VAL_W-1:0] vec_mem [MAX_COLS];

	logic valid_s1;
	logic mat_s1;
	logic re_s1;
	logic [ROW_W-1:0] idx_s1;
	logic last_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic signed [VAL_W-1:0] rd_s1;

	logic valid_s2;
	logic re_s2;
	logic [ROW_W-1:0] idx_s2;
	logic last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum;

	logic out_push;
	result_t out_item;
	logic out_full;
	logic [OUT_CNT_W-1:0] out_count;
	logic [OUT_CNT_W:0] in_flight;
	logic credit_ok;

	// results that are already promised to the output queue
	assign in_flight = (OUT_CNT_W+1)'(out_count)
		+ (OUT_CNT_W+1)'(valid_s1 && mat_s1 && re_s1)
		+ (OUT_CNT_W+1)'(valid_s2 && re_s2);
	assign credit_ok = (in_flight < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign q_pop = !q_empty && credit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1 && mat_s1;
			if (valid_s2) begin
				acc_q <= re_s2 ? '0 : sum;
			end
		end
	end

	// vector store and stage payloads
	always_ff @(posedge clk) begin
		if (q_pop && !op.is_mat) begin
			vec_mem[AW'(op.pos)] <= op.value;
		end
		if (q_pop && op.is_mat) begin
			rd_s1 <= vec_mem[AW'(op.pos)];
		end
		mat_s1 <= op.is_mat;
		re_s1 <= op.row_end;
		idx_s1 <= op.row_idx;
		last_s1 <= op.last;
		val_s1 <= op.value;

		prod_s2 <= val_s1 * rd_s1;
		re_s2 <= re_s1;
		idx_s2 <= idx_s1;
		last_s2 <= last_s1;
	end

	assign sum = acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign out_push = valid_s2 && re_s2;

	always_comb begin
		out_item.row_result = sum;
		out_item.row_index = idx_s2;
		out_item.last_row = last_s2;
	end

	mvm_queue #(
		.item_t(result_t),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wr_item(out_item),
		.pop(pop),
		.rd_item(result),
		.full(out_full),
		.empty(empty),
		.count(out_count)
	);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= (OUT_CNT_W+1)'(OUT_DEPTH))
		else $error("result credit exceeded");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into full queue");

	a_s2_origin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1 && mat_s1))
		else $error("multiply stage valid without matrix request");

endmodule
